>>> hw/rtl/csv_record_encoder_assert.svh
// Assertion macros for the CSV record encoder.
`ifndef CSV_RECORD_ENCODER_ASSERT_SVH
`define CSV_RECORD_ENCODER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CSVENC_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CSVENC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/csvenc_pkg.sv
// Shared constants and control types for the CSV record encoder.
package csvenc_pkg;

    localparam int CELL_BYTES = 16;
    localparam int ADDR_W     = (CELL_BYTES > 1) ? $clog2(CELL_BYTES) : 1;
    localparam int CNT_W      = $clog2(CELL_BYTES + 1);

    localparam logic [1:0] KIND_DATA       = 2'd0;
    localparam logic [1:0] KIND_CELL_END   = 2'd1;
    localparam logic [1:0] KIND_RECORD_END = 2'd2;

    localparam logic [7:0] QUOTE_CH      = 8'h22;
    localparam logic [7:0] CR_CH         = 8'h0D;
    localparam logic [7:0] LF_CH         = 8'h0A;
    localparam logic [7:0] SEP_RESET_VAL = 8'd44;

    typedef enum logic [1:0] {
        SEL_SEP   = 2'd0,
        SEL_QUOTE = 2'd1,
        SEL_DATA  = 2'd2,
        SEL_LF    = 2'd3
    } byte_sel_t;

    typedef struct packed {
        logic      accept_data;
        logic      accept_close;
        logic      end_record;
        logic      advance;
        logic      emit;
        logic      last;
        byte_sel_t sel;
    } cmd_t;

    typedef struct packed {
        logic first;
        logic quote;
        logic end_record;
        logic cnt_zero;
        logic last_idx;
        logic data_is_quote;
        logic out_free;
    } status_t;

endpackage

>>> hw/rtl/csvenc_ifs.sv
// Channel interfaces: cell input, CSV text output, separator write.
interface csvenc_cell_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] cell_byte;

    modport source (output valid, output kind, output cell_byte, input ready);
    modport sink (input valid, input kind, input cell_byte, output ready);
endinterface

interface csvenc_text_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last_of_run;
    logic       truncated;

    modport source (output valid, output out_byte, output last_of_run, output truncated,
                    input ready);
    modport sink (input valid, input out_byte, input last_of_run, input truncated,
                  output ready);
endinterface

interface csvenc_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] separator;

    modport source (output valid, output separator, input ready);
    modport sink (input valid, input separator, output ready);
endinterface

>>> hw/rtl/csvenc_datapath.sv
// Datapath: cell buffer, cell flags, close snapshot and output register.
module csvenc_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  csvenc_pkg::cmd_t    cmd,
    output csvenc_pkg::status_t status,
    input  logic [7:0]          cell_byte,
    input  logic                cfg_we,
    input  logic [7:0]          cfg_data,
    input  logic                out_ready,
    output logic                out_valid,
    output logic [7:0]          out_byte,
    output logic                out_last,
    output logic                out_trunc
);

    logic [7:0] mem [csvenc_pkg::CELL_BYTES];
    logic [7:0] rd_data_reg;

    logic [7:0] sep_reg, sep_next;
    logic [csvenc_pkg::CNT_W-1:0] fill_reg, fill_next;
    logic special_reg, special_next;
    logic first_reg, first_next;
    logic ovf_reg, ovf_next;

    logic [csvenc_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic [csvenc_pkg::CNT_W-1:0] idx_reg, idx_next;
    logic quote_reg, quote_next;
    logic efirst_reg, efirst_next;
    logic eor_reg, eor_next;
    logic trunc_reg, trunc_next;

    logic out_valid_reg, out_valid_next;
    logic [7:0] out_byte_reg;
    logic out_last_reg;
    logic out_trunc_reg;

    logic       has_room;
    logic       is_special;
    logic [7:0] emit_byte;

    assign has_room   = fill_reg < csvenc_pkg::CNT_W'(csvenc_pkg::CELL_BYTES);
    assign is_special = (cell_byte == sep_reg) || (cell_byte == csvenc_pkg::QUOTE_CH)
                     || (cell_byte == csvenc_pkg::CR_CH) || (cell_byte == csvenc_pkg::LF_CH);

    always_comb
    begin
        sep_next     = cfg_we ? cfg_data : sep_reg;
        fill_next    = fill_reg;
        special_next = special_reg;
        first_next   = first_reg;
        ovf_next     = ovf_reg;
        cnt_next     = cnt_reg;
        idx_next     = idx_reg;
        quote_next   = quote_reg;
        efirst_next  = efirst_reg;
        eor_next     = eor_reg;
        trunc_next   = trunc_reg;
        if (cmd.accept_data)
        begin
            if (has_room)
            begin
                fill_next    = fill_reg + csvenc_pkg::CNT_W'(1);
                special_next = special_reg | is_special;
            end
            else
            begin
                ovf_next = 1'b1;
            end
        end
        if (cmd.accept_close)
        begin
            cnt_next     = fill_reg;
            idx_next     = '0;
            quote_next   = special_reg
                        || (cmd.end_record && first_reg && (fill_reg == '0));
            efirst_next  = first_reg;
            eor_next     = cmd.end_record;
            trunc_next   = ovf_reg;
            fill_next    = '0;
            special_next = 1'b0;
            ovf_next     = 1'b0;
            first_next   = cmd.end_record;
        end
        if (cmd.advance)
        begin
            idx_next = idx_reg + csvenc_pkg::CNT_W'(1);
        end
    end

    always_comb
    begin
        unique case (cmd.sel)
            csvenc_pkg::SEL_SEP:   emit_byte = sep_reg;
            csvenc_pkg::SEL_QUOTE: emit_byte = csvenc_pkg::QUOTE_CH;
            csvenc_pkg::SEL_DATA:  emit_byte = rd_data_reg;
            csvenc_pkg::SEL_LF:    emit_byte = csvenc_pkg::LF_CH;
            default:               emit_byte = sep_reg;
        endcase
    end

    assign status.out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sep_reg       <= csvenc_pkg::SEP_RESET_VAL;
            fill_reg      <= '0;
            special_reg   <= 1'b0;
            first_reg     <= 1'b1;
            ovf_reg       <= 1'b0;
            cnt_reg       <= '0;
            idx_reg       <= '0;
            quote_reg     <= 1'b0;
            efirst_reg    <= 1'b1;
            eor_reg       <= 1'b0;
            trunc_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            sep_reg       <= sep_next;
            fill_reg      <= fill_next;
            special_reg   <= special_next;
            first_reg     <= first_next;
            ovf_reg       <= ovf_next;
            cnt_reg       <= cnt_next;
            idx_reg       <= idx_next;
            quote_reg     <= quote_next;
            efirst_reg    <= efirst_next;
            eor_reg       <= eor_next;
            trunc_reg     <= trunc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept_data && has_room)
        begin
            mem[fill_reg[csvenc_pkg::ADDR_W-1:0]] <= cell_byte;
        end
        rd_data_reg <= mem[idx_reg[csvenc_pkg::ADDR_W-1:0]];
        if (cmd.emit)
        begin
            out_byte_reg  <= emit_byte;
            out_last_reg  <= cmd.last;
            out_trunc_reg <= trunc_reg;
        end
    end

    assign status.first         = efirst_reg;
    assign status.quote         = quote_reg;
    assign status.end_record    = eor_reg;
    assign status.cnt_zero      = (cnt_reg == '0);
    assign status.last_idx      = ((idx_reg + csvenc_pkg::CNT_W'(1)) == cnt_reg);
    assign status.data_is_quote = (rd_data_reg == csvenc_pkg::QUOTE_CH);

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign out_last  = out_last_reg;
    assign out_trunc = out_trunc_reg;

endmodule

>>> hw/rtl/csvenc_ctrl.sv
// Controller: sequences cell intake and the bytes of each closed cell.
module csvenc_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic [1:0]          kind,
    output logic                in_ready,
    input  csvenc_pkg::status_t status,
    output csvenc_pkg::cmd_t    cmd
);

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_START  = 7'b0000010,
        ST_SEP    = 7'b0000100,
        ST_OPEN   = 7'b0001000,
        ST_BYTE   = 7'b0010000,
        ST_LOAD   = 7'b0100000,
        ST_CLOSEQ = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    logic   dbl_reg, dbl_next;
    logic   lf_reg, lf_next;

    state_t after_bytes;
    state_t after_sep;
    state_t after_open;
    logic   lf_after;

    // Successor states after each byte phase; the record LF is sent from idle through lf_reg
    always_comb
    begin
        lf_after    = status.end_record;
        after_bytes = status.quote ? ST_CLOSEQ : ST_IDLE;
        after_open  = status.cnt_zero ? after_bytes : ST_BYTE;
        after_sep   = status.quote ? ST_OPEN : after_open;
    end

    always_comb
    begin
        state_next   = state_reg;
        dbl_next     = dbl_reg;
        lf_next      = lf_reg;
        in_ready     = 1'b0;
        cmd          = '0;
        cmd.sel      = csvenc_pkg::SEL_SEP;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (lf_reg)
                begin
                    if (status.out_free)
                    begin
                        cmd.emit = 1'b1;
                        cmd.last = 1'b1;
                        cmd.sel  = csvenc_pkg::SEL_LF;
                        lf_next  = 1'b0;
                    end
                end
                else
                begin
                    in_ready = 1'b1;
                    if (in_valid)
                    begin
                        unique case (kind)
                            csvenc_pkg::KIND_DATA:
                            begin
                                cmd.accept_data = 1'b1;
                            end
                            csvenc_pkg::KIND_CELL_END:
                            begin
                                cmd.accept_close = 1'b1;
                                state_next       = ST_START;
                            end
                            csvenc_pkg::KIND_RECORD_END:
                            begin
                                cmd.accept_close = 1'b1;
                                cmd.end_record   = 1'b1;
                                state_next       = ST_START;
                            end
                            default:
                            begin
                                state_next = ST_IDLE;
                            end
                        endcase
                    end
                end
            end
            ST_START:
            begin
                dbl_next = 1'b0;
                if (!status.first)
                begin
                    state_next = ST_SEP;
                end
                else if (status.quote)
                begin
                    state_next = ST_OPEN;
                end
                else if (!status.cnt_zero)
                begin
                    state_next = ST_BYTE;
                end
                else
                begin
                    state_next = after_bytes;
                    lf_next    = lf_after;
                end
            end
            ST_SEP:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    cmd.sel    = csvenc_pkg::SEL_SEP;
                    cmd.last   = (after_sep == ST_IDLE) && !lf_after;
                    state_next = after_sep;
                    if (after_sep == ST_IDLE)
                    begin
                        lf_next = lf_after;
                    end
                end
            end
            ST_OPEN:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    cmd.sel    = csvenc_pkg::SEL_QUOTE;
                    state_next = after_open;
                end
            end
            ST_BYTE:
            begin
                if (status.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (status.quote && status.data_is_quote && !dbl_reg)
                    begin
                        cmd.sel  = csvenc_pkg::SEL_QUOTE;
                        dbl_next = 1'b1;
                    end
                    else
                    begin
                        cmd.sel  = csvenc_pkg::SEL_DATA;
                        dbl_next = 1'b0;
                        if (status.last_idx)
                        begin
                            cmd.last   = (after_bytes == ST_IDLE) && !lf_after;
                            state_next = after_bytes;
                            if (after_bytes == ST_IDLE)
                            begin
                                lf_next = lf_after;
                            end
                        end
                        else
                        begin
                            cmd.advance = 1'b1;
                            state_next  = ST_LOAD;
                        end
                    end
                end
            end
            ST_LOAD:
            begin
                state_next = ST_BYTE;
            end
            ST_CLOSEQ:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    cmd.sel    = csvenc_pkg::SEL_QUOTE;
                    cmd.last   = !lf_after;
                    lf_next    = lf_after;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            dbl_reg   <= 1'b0;
            lf_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            dbl_reg   <= dbl_next;
            lf_reg    <= lf_next;
        end
    end

endmodule

>>> hw/rtl/csv_record_encoder.sv
// CSV record encoder top level: wires controller, datapath and channels.
//
// Cell bytes arrive as transactions on the cells channel and are buffered,
// one per cycle while the block is idle, in a 16-byte cell buffer; bytes
// beyond that are dropped and every byte of that cell's output is marked
// truncated. An end-of-cell or end-of-record transaction closes the cell
// and the block stops taking input until all of its text has been handed
// to the output register: a dispatch step, then the separator unless the
// cell opens a record, the opening quote of a quoted cell, each buffered
// byte with any doubled quote, the closing quote and, at the end of a
// record, the LF. Each buffered byte but the last needs a load step, as
// the buffer has a single registered read port; output stalls add to this.
// The separator register (reset ',') may be written only while idle.
`include "csv_record_encoder_assert.svh"

module csv_record_encoder (
    input  logic          clk,
    input  logic          rst_n,
    csvenc_cell_if.sink   cells,
    csvenc_text_if.source text,
    csvenc_cfg_if.sink    cfg
);

    csvenc_pkg::cmd_t    cmd;
    csvenc_pkg::status_t status;
    logic                in_fire;
    logic                last_emit;

    assign cfg.ready = 1'b1;
    assign in_fire   = cells.valid && cells.ready;
    assign last_emit = cmd.emit && cmd.last;

    csvenc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (cells.valid),
        .kind     (cells.kind),
        .in_ready (cells.ready),
        .status   (status),
        .cmd      (cmd)
    );

    csvenc_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .cell_byte (cells.cell_byte),
        .cfg_we    (cfg.valid && cfg.ready),
        .cfg_data  (cfg.separator),
        .out_ready (text.ready),
        .out_valid (text.valid),
        .out_byte  (text.out_byte),
        .out_last  (text.last_of_run),
        .out_trunc (text.truncated)
    );

    `CSVENC_ASSERT_SAME(a_emit_into_free, clk, rst_n, cmd.emit, status.out_free, "output busy")
    `CSVENC_ASSERT_SAME(a_no_emit_on_accept, clk, rst_n, in_fire, !cmd.emit, "emit on input")
    `CSVENC_ASSERT_NEXT(a_last_frees_in, clk, rst_n, last_emit, cells.ready, "input held")

endmodule

>>> tb/csvenc_text_checker.sv
`timescale 1ns / 100ps
// Checker for the CSV record encoder: predicts the encoded text and compares every byte.
module csvenc_text_checker (
    input  logic   clk,
    input  logic   rst_n,
    csvenc_cell_if cells,
    csvenc_text_if text,
    csvenc_cfg_if  cfg,
    output int     fail_count,
    output int     pending,
    output int     bytes_checked
);
    import csvenc_pkg::*;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_run;
        logic       truncated;
    } text_byte_t;

    text_byte_t       text_q[$];
    logic [7:0]       cell_buf[CELL_BYTES];
    logic [CNT_W-1:0] fill;
    logic             quote_due;
    logic             first_of_record;
    logic             dropped;
    logic [7:0]       sep;

    function automatic void encode_cell(input logic end_record);
        logic [7:0] run[$];
        logic       quoted;
        int         i;
        quoted = quote_due || (end_record && first_of_record && fill == 0);
        if (!first_of_record)
            run.push_back(sep);
        if (quoted)
            run.push_back(QUOTE_CH);
        for (i = 0; i < int'(fill); i++)
        begin
            if (quoted && cell_buf[i] == QUOTE_CH)
                run.push_back(QUOTE_CH);
            run.push_back(cell_buf[i]);
        end
        if (quoted)
            run.push_back(QUOTE_CH);
        if (end_record)
            run.push_back(LF_CH);
        for (i = 0; i < run.size(); i++)
            text_q.push_back('{out_byte: run[i], last_of_run: (i == run.size() - 1),
                               truncated: dropped});
        fill            = '0;
        quote_due       = 1'b0;
        dropped         = 1'b0;
        first_of_record = end_record;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        text_byte_t want;
        if (!rst_n)
        begin
            fill            = '0;
            quote_due       = 1'b0;
            first_of_record = 1'b1;
            dropped         = 1'b0;
            sep             = SEP_RESET_VAL;
            fail_count      = 0;
            bytes_checked   = 0;
            text_q.delete();
        end
        else
        begin
            if (text.valid && text.ready)
            begin
                if (text_q.size() == 0)
                begin
                    $error("unexpected text byte %02h with nothing outstanding", text.out_byte);
                    fail_count++;
                end
                else
                begin
                    want = text_q.pop_front();
                    bytes_checked++;
                    if (text.out_byte !== want.out_byte)
                    begin
                        $error("out_byte: expected %02h, got %02h", want.out_byte, text.out_byte);
                        fail_count++;
                    end
                    if (text.last_of_run !== want.last_of_run)
                    begin
                        $error("last_of_run: expected %0b, got %0b",
                               want.last_of_run, text.last_of_run);
                        fail_count++;
                    end
                    if (text.truncated !== want.truncated)
                    begin
                        $error("truncated: expected %0b, got %0b", want.truncated, text.truncated);
                        fail_count++;
                    end
                end
            end
            if (cells.valid && cells.ready)
            begin
                case (cells.kind)
                    KIND_DATA:
                    begin
                        if (fill < CELL_BYTES)
                        begin
                            cell_buf[fill[ADDR_W-1:0]] = cells.cell_byte;
                            fill                       = fill + CNT_W'(1);
                            if (cells.cell_byte == sep || cells.cell_byte == QUOTE_CH ||
                                cells.cell_byte == CR_CH || cells.cell_byte == LF_CH)
                                quote_due = 1'b1;
                        end
                        else
                            dropped = 1'b1;
                    end
                    KIND_CELL_END:   encode_cell(1'b0);
                    KIND_RECORD_END: encode_cell(1'b1);
                    default: ;
                endcase
            end
            if (cfg.valid && cfg.ready)
                sep = cfg.separator;
        end
        pending = text_q.size();
    end
endmodule

>>> tb/tb.sv
`timescale 1ns / 100ps
// Testbench top for the CSV record encoder: stimulus, flow control and verdict.
module tb;
    import csvenc_pkg::*;

    localparam logic [1:0] KIND_UNUSED   = 2'd3;
    localparam int         SETTLE_CYCLES = 64;
    localparam int         HOLD_CYCLES   = 400;
    localparam int         PHASE_ITEMS   = 28;

    logic       clk;
    logic       rst_n;
    int         fail_count;
    int         pending;
    int         bytes_checked;
    int         send_idle_pct  = 0;
    int         recv_stall_pct = 0;
    int         hold_left      = 0;
    logic       hold_go        = 1'b0;
    logic       hold_taken     = 1'b0;
    int         items_sent     = 0;
    int         records_sent   = 0;
    int         sep_writes     = 0;
    logic [7:0] cur_sep        = SEP_RESET_VAL;

    csvenc_cell_if cells ();
    csvenc_text_if text ();
    csvenc_cfg_if  cfg ();

    csv_record_encoder dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cells (cells),
        .text  (text),
        .cfg   (cfg)
    );

    csvenc_text_checker chk (
        .clk           (clk),
        .rst_n         (rst_n),
        .cells         (cells),
        .text          (text),
        .cfg           (cfg),
        .fail_count    (fail_count),
        .pending       (pending),
        .bytes_checked (bytes_checked)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    always @(posedge clk)
    begin
        if (hold_left != 0)
        begin
            text.ready <= 1'b0;
            hold_left  <= hold_left - 1;
        end
        else if (hold_go && !hold_taken)
        begin
            text.ready <= 1'b0;
            hold_left  <= HOLD_CYCLES;
            hold_taken <= 1'b1;
        end
        else
            text.ready <= rst_n && ($urandom_range(0, 99) >= recv_stall_pct);
    end

    function automatic logic [7:0] pick_cell_byte();
        case ($urandom_range(0, 19))
            0:                        return QUOTE_CH;
            1:                        return cur_sep;
            2:                        return CR_CH;
            3:                        return LF_CH;
            4, 5, 6, 7, 8, 9, 10, 11: return 8'($urandom_range(32, 126));
            default:                  return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic send_cell(input logic [1:0] kind, input logic [7:0] value);
        if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct)
        begin
            cells.valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < send_idle_pct);
        end
        cells.valid     <= 1'b1;
        cells.kind      <= kind;
        cells.cell_byte <= value;
        do
            @(posedge clk);
        while (cells.ready !== 1'b1);
        if (kind != KIND_UNUSED)
            items_sent++;
    endtask

    task automatic drain_text();
        cells.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_separator(input logic [7:0] value);
        cfg.valid     <= 1'b1;
        cfg.separator <= value;
        do
            @(posedge clk);
        while (cfg.ready !== 1'b1);
        cfg.valid <= 1'b0;
        @(posedge clk);
        cur_sep = value;
        sep_writes++;
    endtask

    task automatic send_record();
        int n_cells;
        int len;
        int c;
        int i;
        n_cells = $urandom_range(1, 4);
        for (c = 0; c < n_cells; c++)
        begin
            if ($urandom_range(0, 9) == 0)
                len = $urandom_range(CELL_BYTES - 2, CELL_BYTES + 4);
            else
                len = $urandom_range(0, 6);
            for (i = 0; i < len; i++)
                send_cell(KIND_DATA, pick_cell_byte());
            send_cell((c == n_cells - 1) ? KIND_RECORD_END : KIND_CELL_END,
                      8'($urandom_range(0, 255)));
        end
        records_sent++;
    endtask

    task automatic send_noise();
        int n;
        int i;
        n = $urandom_range(1, 6);
        for (i = 0; i < n; i++)
            send_cell(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
    endtask

    task automatic run_phase(input logic [7:0] sep, input int idle_pct, input int stall_pct,
                             input logic long_hold);
        int target;
        send_idle_pct  <= idle_pct;
        recv_stall_pct <= stall_pct;
        write_separator(sep);
        if (long_hold)
            hold_go <= 1'b1;
        target = items_sent + PHASE_ITEMS;
        while (items_sent < target)
        begin
            if ($urandom_range(0, 9) == 0)
                send_noise();
            else
                send_record();
        end
        drain_text();
    endtask

    initial
    begin
        int i;
        rst_n           = 1'b0;
        cells.valid     = 1'b0;
        cells.kind      = KIND_DATA;
        cells.cell_byte = 8'h00;
        cfg.valid       = 1'b0;
        cfg.separator   = SEP_RESET_VAL;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        send_cell(KIND_RECORD_END, 8'h00);
        send_cell(KIND_DATA, 8'h00);
        send_cell(KIND_DATA, 8'hFF);
        send_cell(KIND_CELL_END, 8'hFF);
        send_cell(KIND_CELL_END, 8'h00);
        send_cell(KIND_DATA, cur_sep);
        send_cell(KIND_DATA, QUOTE_CH);
        send_cell(KIND_DATA, CR_CH);
        send_cell(KIND_DATA, LF_CH);
        send_cell(KIND_RECORD_END, 8'h00);
        send_cell(KIND_UNUSED, 8'hA5);
        send_cell(KIND_CELL_END, 8'h00);
        for (i = 0; i < CELL_BYTES; i++)
            send_cell(KIND_DATA, 8'h41 + 8'(i));
        send_cell(KIND_DATA, QUOTE_CH);
        send_cell(KIND_RECORD_END, 8'h00);
        drain_text();
        write_separator(8'h3B);
        send_cell(KIND_DATA, 8'h3B);
        drain_text();
        write_separator(SEP_RESET_VAL);
        send_cell(KIND_RECORD_END, 8'h00);
        drain_text();

        run_phase(8'h3B,         0,  0,  1'b0);
        run_phase(8'hFF,         69, 0,  1'b0);
        run_phase(8'h01,         0,  69, 1'b0);
        run_phase(8'h09,         11, 11, 1'b0);
        run_phase(QUOTE_CH,      0,  0,  1'b0);
        run_phase(CR_CH,         69, 0,  1'b0);
        run_phase(LF_CH,         0,  69, 1'b0);
        run_phase(SEP_RESET_VAL, 0,  0,  1'b1);

        if (pending != 0)
            $error("%0d expected text bytes never arrived", pending);
        $display("Sent %0d items (%0d random records) across %0d separator writes,",
                 items_sent, records_sent, sep_writes);
        $display("including overflow, quoting, odd separators and a long output stall;");
        $display("%0d bytes checked.", bytes_checked);
        if (fail_count == 0 && pending == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $error("timeout with %0d text bytes outstanding", pending);
        $display("Test completed with failures");
        $finish;
    end
endmodule

>>> files.f
+incdir+hw/rtl
hw/rtl/csvenc_pkg.sv
hw/rtl/csvenc_ifs.sv
hw/rtl/csvenc_datapath.sv
hw/rtl/csvenc_ctrl.sv
hw/rtl/csv_record_encoder.sv
tb/csvenc_text_checker.sv
tb/tb.sv
